[hdl/xmltok_pkg.sv]
// Package for the markup tokenizer: payload structs, phase, event and error
// codes, byte constants and character class helpers. No dependencies.
package xmltok_pkg;

    localparam int LINE_BITS = 16;
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

    localparam logic [7:0] C_LT    = 8'h3C;
    localparam logic [7:0] C_GT    = 8'h3E;
    localparam logic [7:0] C_SLASH = 8'h2F;
    localparam logic [7:0] C_BANG  = 8'h21;
    localparam logic [7:0] C_QMARK = 8'h3F;
    localparam logic [7:0] C_DASH  = 8'h2D;
    localparam logic [7:0] C_UNDER = 8'h5F;
    localparam logic [7:0] C_NL    = 8'h0A;
    localparam logic [7:0] C_EQ    = 8'h3D;
    localparam logic [7:0] C_SQUOT = 8'h27;
    localparam logic [7:0] C_DQUOT = 8'h22;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_DEL   = 8'h7F;

    typedef enum logic [12:0] {
        PH_START   = 13'b0_0000_0000_0001,
        PH_TAG     = 13'b0_0000_0000_0010,
        PH_INTAG   = 13'b0_0000_0000_0100,
        PH_COMMENT = 13'b0_0000_0000_1000,
        PH_CEND1   = 13'b0_0000_0001_0000,
        PH_CEND2   = 13'b0_0000_0010_0000,
        PH_ATTRN   = 13'b0_0000_0100_0000,
        PH_INATTRN = 13'b0_0000_1000_0000,
        PH_ATTRV   = 13'b0_0001_0000_0000,
        PH_SLASH   = 13'b0_0010_0000_0000,
        PH_INATTRV = 13'b0_0100_0000_0000,
        PH_CLOSE   = 13'b0_1000_0000_0000,
        PH_INCLOSE = 13'b1_0000_0000_0000
    } t_phase;

    typedef enum logic [3:0] {
        EV_NONE    = 4'd0,
        EV_TEXTEND = 4'd1,
        EV_TEXT    = 4'd2,
        EV_TAG     = 4'd3,
        EV_CTAG    = 4'd4,
        EV_ATTRN   = 4'd5,
        EV_VSTART  = 4'd6,
        EV_VALUE   = 4'd7,
        EV_COMMIT  = 4'd8,
        EV_ESTART  = 4'd9,
        EV_EEND    = 4'd10,
        EV_ERROR   = 4'd11
    } t_event;

    typedef enum logic [2:0] {
        ER_NONE       = 3'd0,
        ER_TAG_CHAR   = 3'd1,
        ER_ATTR_FIRST = 3'd2,
        ER_SLASH      = 3'd3,
        ER_ATTR_CHAR  = 3'd4,
        ER_NO_VALUE   = 3'd5,
        ER_CLOSE_LEAD = 3'd6,
        ER_CLOSE_CHAR = 3'd7
    } t_err;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       new_document;
    } t_in;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [7:0]  out_byte;
        logic        name_first;
        logic [15:0] line_number;
        logic [2:0]  error_code;
        logic        last;
    } t_out;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_name_start(input logic [7:0] c);
        return is_letter(c) || c == C_UNDER;
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return is_letter(c) || c == C_UNDER || is_digit(c);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == C_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_ctrl(input logic [7:0] c);
        return c < C_SPACE || c == C_DEL;
    endfunction

endpackage

[hdl/xml_markup_tokenizer_unit.sv]
// Top level of the streaming markup tokenizer: byte recognizer and result queue.
// Depends on xmltok_pkg.
//
// Takes one document byte per cycle and streams tag, attribute, text and error
// events; a new transaction is taken every cycle while the four-entry result
// queue has room for two results, so the sustained rate is one byte per cycle
// as long as results are drained. The recognizer state (phase, line count,
// quote, skip and halt flags) is updated in the accepting cycle; each byte
// yields one result, a '/>' ending yields two (element start, element end),
// and a byte arriving while halted after an error yields none until a byte
// with new_document set.
module xml_markup_tokenizer_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  xmltok_pkg::t_in   i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output xmltok_pkg::t_out  o_result
);

    // recognizer state
    xmltok_pkg::t_phase                  r_phase, n_phase;
    logic [xmltok_pkg::LINE_BITS-1:0]    r_line, n_line;
    logic                                r_skip, n_skip;
    logic [7:0]                          r_quote, n_quote;
    logic                                r_halt, n_halt;

    // result queue
    xmltok_pkg::t_out r_q [4];
    logic [1:0]       r_wr, r_rd;
    logic [2:0]       r_count, n_count;

    logic             in_acc, out_acc;
    logic [1:0]       n_res;
    xmltok_pkg::t_out res0, res1;

    xmltok_pkg::t_phase               e_phase;
    logic [xmltok_pkg::LINE_BITS-1:0] e_line;
    logic                             e_skip, e_halt;
    logic [7:0]                       e_quote;
    logic [7:0]                       c;
    xmltok_pkg::t_event               ev;
    xmltok_pkg::t_err                 err;
    logic                             nf;

    assign o_ready = (r_count <= 3'd2);
    assign in_acc  = i_valid && o_ready;
    assign o_valid = (r_count != 3'd0);
    assign out_acc = o_valid && i_ready;
    assign o_result = r_q[r_rd];
    assign c = i_item.in_byte;

    always_comb begin
        e_phase = i_item.new_document ? xmltok_pkg::PH_START : r_phase;
        e_line  = i_item.new_document ? xmltok_pkg::LINE_ONE : r_line;
        e_skip  = i_item.new_document ? 1'b0 : r_skip;
        e_quote = i_item.new_document ? 8'h00 : r_quote;
        e_halt  = i_item.new_document ? 1'b0 : r_halt;

        n_phase = e_phase;
        n_skip  = e_skip;
        n_quote = e_quote;
        n_halt  = e_halt;
        n_line  = e_line;
        ev      = xmltok_pkg::EV_NONE;
        err     = xmltok_pkg::ER_NONE;
        nf      = 1'b0;
        n_res   = 2'd0;

        if (!e_halt) begin
            n_res = 2'd1;
            if (c == xmltok_pkg::C_NL && e_line != xmltok_pkg::LINE_MAX) begin
                n_line = e_line + xmltok_pkg::LINE_ONE;
            end
            unique case (e_phase)
                xmltok_pkg::PH_TAG: begin
                    if (e_skip) begin
                        if (c == xmltok_pkg::C_GT) begin
                            n_skip  = 1'b0;
                            n_phase = xmltok_pkg::PH_START;
                        end
                    end else if (c == xmltok_pkg::C_QMARK) begin
                        n_skip = 1'b1;
                    end else if (xmltok_pkg::is_name_start(c)) begin
                        ev = xmltok_pkg::EV_TAG; nf = 1'b1;
                        n_phase = xmltok_pkg::PH_INTAG;
                    end else if (c == xmltok_pkg::C_SLASH) begin
                        n_phase = xmltok_pkg::PH_CLOSE;
                    end else if (c == xmltok_pkg::C_BANG) begin
                        n_phase = xmltok_pkg::PH_COMMENT;
                    end else if (!xmltok_pkg::is_space(c)) begin
                        err = xmltok_pkg::ER_TAG_CHAR;
                    end
                end
                xmltok_pkg::PH_INTAG: begin
                    if (xmltok_pkg::is_name_char(c)) begin
                        ev = xmltok_pkg::EV_TAG;
                    end else if (c == xmltok_pkg::C_GT) begin
                        ev = xmltok_pkg::EV_ESTART;
                        n_phase = xmltok_pkg::PH_START;
                    end else if (c == xmltok_pkg::C_SLASH) begin
                        n_phase = xmltok_pkg::PH_SLASH;
                    end else begin
                        n_phase = xmltok_pkg::PH_ATTRN;
                    end
                end
                xmltok_pkg::PH_COMMENT: begin
                    if (c == xmltok_pkg::C_DASH) begin
                        n_phase = xmltok_pkg::PH_CEND1;
                    end
                end
                xmltok_pkg::PH_CEND1: begin
                    n_phase = (c == xmltok_pkg::C_DASH) ? xmltok_pkg::PH_CEND2
                                                        : xmltok_pkg::PH_COMMENT;
                end
                xmltok_pkg::PH_CEND2: begin
                    if (c == xmltok_pkg::C_GT) begin
                        n_phase = xmltok_pkg::PH_START;
                    end else if (c != xmltok_pkg::C_DASH) begin
                        n_phase = xmltok_pkg::PH_COMMENT;
                    end
                end
                xmltok_pkg::PH_ATTRN: begin
                    if (c == xmltok_pkg::C_GT) begin
                        ev = xmltok_pkg::EV_ESTART;
                        n_phase = xmltok_pkg::PH_START;
                    end else if (c == xmltok_pkg::C_SLASH) begin
                        n_phase = xmltok_pkg::PH_SLASH;
                    end else if (xmltok_pkg::is_name_start(c)) begin
                        ev = xmltok_pkg::EV_ATTRN; nf = 1'b1;
                        n_phase = xmltok_pkg::PH_INATTRN;
                    end else if (!xmltok_pkg::is_space(c)) begin
                        err = xmltok_pkg::ER_ATTR_FIRST;
                    end
                end
                xmltok_pkg::PH_SLASH: begin
                    if (c == xmltok_pkg::C_GT) begin
                        // self-closing element: start then end
                        ev = xmltok_pkg::EV_ESTART;
                        n_phase = xmltok_pkg::PH_START;
                        n_res = 2'd2;
                    end else begin
                        err = xmltok_pkg::ER_SLASH;
                    end
                end
                xmltok_pkg::PH_INATTRN: begin
                    if (xmltok_pkg::is_name_char(c)) begin
                        ev = xmltok_pkg::EV_ATTRN;
                    end else if (xmltok_pkg::is_space(c) || c == xmltok_pkg::C_EQ) begin
                        n_phase = xmltok_pkg::PH_ATTRV;
                    end else begin
                        err = xmltok_pkg::ER_ATTR_CHAR;
                    end
                end
                xmltok_pkg::PH_ATTRV: begin
                    if (c == xmltok_pkg::C_SQUOT || c == xmltok_pkg::C_DQUOT) begin
                        n_quote = c;
                        ev = xmltok_pkg::EV_VSTART;
                        n_phase = xmltok_pkg::PH_INATTRV;
                    end else if (!(xmltok_pkg::is_space(c) || c == xmltok_pkg::C_EQ)) begin
                        err = xmltok_pkg::ER_NO_VALUE;
                    end
                end
                xmltok_pkg::PH_INATTRV: begin
                    if (c == e_quote) begin
                        ev = xmltok_pkg::EV_COMMIT;
                        n_phase = xmltok_pkg::PH_ATTRN;
                    end else if (!xmltok_pkg::is_ctrl(c)) begin
                        ev = xmltok_pkg::EV_VALUE;
                    end
                end
                xmltok_pkg::PH_CLOSE: begin
                    if (xmltok_pkg::is_name_start(c)) begin
                        ev = xmltok_pkg::EV_CTAG; nf = 1'b1;
                        n_phase = xmltok_pkg::PH_INCLOSE;
                    end else if (!xmltok_pkg::is_space(c)) begin
                        err = xmltok_pkg::ER_CLOSE_LEAD;
                    end
                end
                xmltok_pkg::PH_INCLOSE: begin
                    if (xmltok_pkg::is_name_char(c)) begin
                        ev = xmltok_pkg::EV_CTAG;
                    end else if (c == xmltok_pkg::C_GT) begin
                        ev = xmltok_pkg::EV_EEND;
                        n_phase = xmltok_pkg::PH_START;
                    end else if (!xmltok_pkg::is_space(c)) begin
                        err = xmltok_pkg::ER_CLOSE_CHAR;
                    end
                end
                default: begin
                    if (c == xmltok_pkg::C_LT) begin
                        ev = xmltok_pkg::EV_TEXTEND;
                        n_phase = xmltok_pkg::PH_TAG;
                    end else begin
                        ev = xmltok_pkg::EV_TEXT;
                        n_phase = xmltok_pkg::PH_START;
                    end
                end
            endcase
            if (err != xmltok_pkg::ER_NONE) begin
                ev = xmltok_pkg::EV_ERROR;
                nf = 1'b0;
                n_halt = 1'b1;
            end
        end

        res0.event_res   = ev;
        res0.out_byte    = c;
        res0.name_first  = nf;
        res0.line_number = 16'(n_line);
        res0.error_code  = err;
        res0.last        = (n_res == 2'd1);

        res1.event_res   = xmltok_pkg::EV_EEND;
        res1.out_byte    = c;
        res1.name_first  = 1'b0;
        res1.line_number = 16'(n_line);
        res1.error_code  = xmltok_pkg::ER_NONE;
        res1.last        = 1'b1;
    end

    always_comb begin
        n_count = r_count;
        if (in_acc) begin
            n_count = n_count + 3'(n_res);
        end
        if (out_acc) begin
            n_count = n_count - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= xmltok_pkg::PH_START;
            r_line  <= xmltok_pkg::LINE_ONE;
            r_skip  <= 1'b0;
            r_quote <= 8'h00;
            r_halt  <= 1'b0;
            r_wr    <= 2'd0;
            r_rd    <= 2'd0;
            r_count <= 3'd0;
        end else begin
            if (in_acc) begin
                r_phase <= n_phase;
                r_line  <= n_line;
                r_skip  <= n_skip;
                r_quote <= n_quote;
                r_halt  <= n_halt;
                r_wr    <= r_wr + n_res;
            end
            if (out_acc) begin
                r_rd <= r_rd + 2'd1;
            end
            r_count <= n_count;
        end
    end

    // queue payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc && n_res != 2'd0) begin
            r_q[r_wr] <= res0;
        end
        if (in_acc && n_res == 2'd2) begin
            r_q[r_wr + 2'd1] <= res1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result queue overfilled");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0)
        else $error("line count dropped to zero");

    a_halt_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_halt && !i_item.new_document
        |=> $stable(r_phase) && $stable(r_line) && (r_count <= $past(r_count)))
        else $error("halted tokenizer changed state or queued a result");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 3'd4) || (2'(r_wr - r_rd) == r_count[1:0]))
        else $error("queue pointers disagree with count");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for xml_markup_tokenizer_unit: directed bytes and random
// documents, scored by an in-bench tokenizer; typed directed rows pin event and code.
// Depends on xmltok_pkg and the tokenizer RTL.
module testbench;

    localparam int IDLE_PCT       = 16;
    localparam int RANDOM_ITEMS   = 330;
    localparam int CALM_ITEMS     = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    xmltok_pkg::t_in  i_item;
    logic o_valid;
    logic i_ready;
    xmltok_pkg::t_out o_result;

    xml_markup_tokenizer_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    // tokenizer state mirrored by the bench
    xmltok_pkg::t_phase phase;
    logic [15:0] line_cnt;
    logic        skip_decl;
    logic [7:0]  quote_byte;
    logic        halted;

    xmltok_pkg::t_out pending_tokens[$];

    typedef struct {
        logic [7:0] b;
        logic       nd;
    } t_doc_byte;
    t_doc_byte doc_bytes[$];

    typedef struct {
        logic [7:0]         b;
        logic               nd;
        bit                 typed;
        xmltok_pkg::t_event ev;
        xmltok_pkg::t_err   err;
    } t_dir_row;
    t_dir_row dir_rows[$];

    int mismatches;
    int tokens_checked;
    int bytes_sent;
    int bytes_tokenized;
    int docs_sent;
    int stall_cycles;
    bit calm;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic bit name_byte(input bit first, input logic [7:0] c);
        return alpha(c) || c == xmltok_pkg::C_UNDER
            || (!first && c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic bit blank(input logic [7:0] c);
        return c == xmltok_pkg::C_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit ctrl_byte(input logic [7:0] c);
        return c < 8'h20 || c == xmltok_pkg::C_DEL;
    endfunction

    function automatic void restart_parser();
        phase      = xmltok_pkg::PH_START;
        line_cnt   = 16'd1;
        skip_decl  = 1'b0;
        quote_byte = 8'h00;
        halted     = 1'b0;
    endfunction

    function automatic void push_token(input xmltok_pkg::t_event ev, input logic [7:0] c,
                                       input logic nf, input xmltok_pkg::t_err err,
                                       input logic lst);
        xmltok_pkg::t_out t;
        t.event_res   = ev;
        t.out_byte    = c;
        t.name_first  = nf;
        t.line_number = line_cnt;
        t.error_code  = err;
        t.last        = lst;
        pending_tokens.push_back(t);
    endfunction

    // Advances the mirrored tokenizer by one byte, queues its tokens, returns their count.
    function automatic int tokenize_byte(input logic [7:0] c, input logic nd);
        xmltok_pkg::t_event ev;
        xmltok_pkg::t_err   err;
        logic               nf;
        ev  = xmltok_pkg::EV_NONE;
        err = xmltok_pkg::ER_NONE;
        nf  = 1'b0;
        if (nd)
            restart_parser();
        if (halted)
            return 0;
        if (c == xmltok_pkg::C_NL && line_cnt != xmltok_pkg::LINE_MAX)
            line_cnt++;
        case (phase)
            xmltok_pkg::PH_TAG: begin
                if (skip_decl) begin
                    if (c == xmltok_pkg::C_GT) begin
                        skip_decl = 1'b0;
                        phase     = xmltok_pkg::PH_START;
                    end
                end else if (c == xmltok_pkg::C_QMARK) begin
                    skip_decl = 1'b1;
                end else if (name_byte(1'b1, c)) begin
                    ev = xmltok_pkg::EV_TAG; nf = 1'b1; phase = xmltok_pkg::PH_INTAG;
                end else if (c == xmltok_pkg::C_SLASH) begin
                    phase = xmltok_pkg::PH_CLOSE;
                end else if (c == xmltok_pkg::C_BANG) begin
                    phase = xmltok_pkg::PH_COMMENT;
                end else if (!blank(c)) begin
                    err = xmltok_pkg::ER_TAG_CHAR;
                end
            end
            xmltok_pkg::PH_INTAG: begin
                if (name_byte(1'b0, c)) begin
                    ev = xmltok_pkg::EV_TAG;
                end else if (c == xmltok_pkg::C_GT) begin
                    ev = xmltok_pkg::EV_ESTART; phase = xmltok_pkg::PH_START;
                end else if (c == xmltok_pkg::C_SLASH) begin
                    phase = xmltok_pkg::PH_SLASH;
                end else begin
                    phase = xmltok_pkg::PH_ATTRN;
                end
            end
            xmltok_pkg::PH_COMMENT: begin
                if (c == xmltok_pkg::C_DASH)
                    phase = xmltok_pkg::PH_CEND1;
            end
            xmltok_pkg::PH_CEND1: begin
                phase = (c == xmltok_pkg::C_DASH) ? xmltok_pkg::PH_CEND2
                                                  : xmltok_pkg::PH_COMMENT;
            end
            xmltok_pkg::PH_CEND2: begin
                if (c == xmltok_pkg::C_GT)
                    phase = xmltok_pkg::PH_START;
                else if (c != xmltok_pkg::C_DASH)
                    phase = xmltok_pkg::PH_COMMENT;
            end
            xmltok_pkg::PH_ATTRN: begin
                if (c == xmltok_pkg::C_GT) begin
                    ev = xmltok_pkg::EV_ESTART; phase = xmltok_pkg::PH_START;
                end else if (c == xmltok_pkg::C_SLASH) begin
                    phase = xmltok_pkg::PH_SLASH;
                end else if (name_byte(1'b1, c)) begin
                    ev = xmltok_pkg::EV_ATTRN; nf = 1'b1; phase = xmltok_pkg::PH_INATTRN;
                end else if (!blank(c)) begin
                    err = xmltok_pkg::ER_ATTR_FIRST;
                end
            end
            xmltok_pkg::PH_SLASH: begin
                // '/>' closes the element on the spot: start then end
                if (c == xmltok_pkg::C_GT) begin
                    phase = xmltok_pkg::PH_START;
                    push_token(xmltok_pkg::EV_ESTART, c, 1'b0, xmltok_pkg::ER_NONE, 1'b0);
                    push_token(xmltok_pkg::EV_EEND, c, 1'b0, xmltok_pkg::ER_NONE, 1'b1);
                    return 2;
                end
                err = xmltok_pkg::ER_SLASH;
            end
            xmltok_pkg::PH_INATTRN: begin
                if (name_byte(1'b0, c))
                    ev = xmltok_pkg::EV_ATTRN;
                else if (blank(c) || c == xmltok_pkg::C_EQ)
                    phase = xmltok_pkg::PH_ATTRV;
                else
                    err = xmltok_pkg::ER_ATTR_CHAR;
            end
            xmltok_pkg::PH_ATTRV: begin
                if (c == xmltok_pkg::C_SQUOT || c == xmltok_pkg::C_DQUOT) begin
                    quote_byte = c; ev = xmltok_pkg::EV_VSTART;
                    phase = xmltok_pkg::PH_INATTRV;
                end else if (!(blank(c) || c == xmltok_pkg::C_EQ)) begin
                    err = xmltok_pkg::ER_NO_VALUE;
                end
            end
            xmltok_pkg::PH_INATTRV: begin
                if (c == quote_byte) begin
                    ev = xmltok_pkg::EV_COMMIT; phase = xmltok_pkg::PH_ATTRN;
                end else if (!ctrl_byte(c)) begin
                    ev = xmltok_pkg::EV_VALUE;
                end
            end
            xmltok_pkg::PH_CLOSE: begin
                if (name_byte(1'b1, c)) begin
                    ev = xmltok_pkg::EV_CTAG; nf = 1'b1; phase = xmltok_pkg::PH_INCLOSE;
                end else if (!blank(c)) begin
                    err = xmltok_pkg::ER_CLOSE_LEAD;
                end
            end
            xmltok_pkg::PH_INCLOSE: begin
                if (name_byte(1'b0, c)) begin
                    ev = xmltok_pkg::EV_CTAG;
                end else if (c == xmltok_pkg::C_GT) begin
                    ev = xmltok_pkg::EV_EEND; phase = xmltok_pkg::PH_START;
                end else if (!blank(c)) begin
                    err = xmltok_pkg::ER_CLOSE_CHAR;
                end
            end
            default: begin
                if (c == xmltok_pkg::C_LT) begin
                    ev = xmltok_pkg::EV_TEXTEND; phase = xmltok_pkg::PH_TAG;
                end else begin
                    ev = xmltok_pkg::EV_TEXT; phase = xmltok_pkg::PH_START;
                end
            end
        endcase
        if (err != xmltok_pkg::ER_NONE) begin
            ev = xmltok_pkg::EV_ERROR; nf = 1'b0; halted = 1'b1;
        end
        push_token(ev, c, nf, err, 1'b1);
        return 1;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        $display("%0t: %s: got %0d, wanted %0d", $time, what, got, want);
    endtask

    task automatic check_token(input xmltok_pkg::t_out got);
        xmltok_pkg::t_out want;
        if (pending_tokens.size() == 0) begin
            report_mismatch("result with nothing outstanding, event", got.event_res, 0);
            return;
        end
        want = pending_tokens.pop_front();
        tokens_checked++;
        if (got.event_res !== want.event_res)
            report_mismatch("event_res", got.event_res, want.event_res);
        if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", got.out_byte, want.out_byte);
        if (got.name_first !== want.name_first)
            report_mismatch("name_first", got.name_first, want.name_first);
        if (got.line_number !== want.line_number)
            report_mismatch("line_number", got.line_number, want.line_number);
        if (got.error_code !== want.error_code)
            report_mismatch("error_code", got.error_code, want.error_code);
        if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            check_token(o_result);
    end

    always @(negedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Entered and left just after a falling edge; holds the byte until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic nd, output int n);
        xmltok_pkg::t_in it;
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        it.in_byte      = b;
        it.new_document = nd;
        i_valid <= 1'b1;
        i_item  <= it;
        do
            @(posedge i_clk);
        while (!o_ready);
        n = tokenize_byte(b, nd);
        bytes_sent++;
        if (n > 0)
            bytes_tokenized++;
        @(negedge i_clk);
    endtask

    function automatic void row(input logic [7:0] b, input logic nd, input bit typed,
                                input xmltok_pkg::t_event ev, input xmltok_pkg::t_err err);
        t_dir_row r;
        r.b = b; r.nd = nd; r.typed = typed; r.ev = ev; r.err = err;
        dir_rows.push_back(r);
    endfunction

    // ---------------- random document builder ----------------
    task automatic put(input logic [7:0] b);
        t_doc_byte d;
        d.b  = ($urandom_range(99) < 3) ? 8'($urandom_range(255)) : b;
        d.nd = 1'b0;
        doc_bytes.push_back(d);
    endtask

    function automatic logic [7:0] pick_name_byte(input bit first);
        int r;
        r = $urandom_range(first ? 52 : 62);
        if (r < 26)
            return 8'(8'h41 + r);
        if (r < 52)
            return 8'(8'h61 + r - 26);
        if (r == 52)
            return xmltok_pkg::C_UNDER;
        return 8'(8'h30 + r - 53);
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(3))
            0: return xmltok_pkg::C_SPACE;
            1: return 8'h09;
            2: return xmltok_pkg::C_NL;
            default: return 8'h0D;
        endcase
    endfunction

    task automatic put_name();
        put(pick_name_byte(1'b1));
        repeat ($urandom_range(4)) put(pick_name_byte(1'b0));
    endtask

    task automatic put_blanks();
        repeat ($urandom_range(1)) put(pick_blank());
    endtask

    task automatic put_text();
        logic [7:0] b;
        repeat ($urandom_range(4)) begin
            case ($urandom_range(7))
                0, 1, 2, 3: b = 8'(8'h61 + $urandom_range(25));
                4: b = xmltok_pkg::C_NL;
                5: b = xmltok_pkg::C_SPACE;
                default: begin
                    b = 8'($urandom_range(255));
                    if (b == xmltok_pkg::C_LT)
                        b = 8'hC3;
                end
            endcase
            put(b);
        end
    endtask

    task automatic put_close_tag();
        put(xmltok_pkg::C_LT);
        put(xmltok_pkg::C_SLASH);
        put_blanks();
        put_name();
        put_blanks();
        put(xmltok_pkg::C_GT);
    endtask

    task automatic put_element();
        logic [7:0] q;
        logic [7:0] b;
        put(xmltok_pkg::C_LT);
        put_name();
        repeat ($urandom_range(3)) begin
            put(pick_blank());
            put_blanks();
            put_name();
            put($urandom_range(1) ? xmltok_pkg::C_EQ : pick_blank());
            put_blanks();
            q = $urandom_range(1) ? xmltok_pkg::C_DQUOT : xmltok_pkg::C_SQUOT;
            put(q);
            repeat ($urandom_range(5)) begin
                b = 8'($urandom_range(255));
                put((b == q) ? 8'h76 : b);
            end
            put(q);
        end
        put_blanks();
        if ($urandom_range(1)) begin
            put(xmltok_pkg::C_SLASH);
            put(xmltok_pkg::C_GT);
        end else begin
            put(xmltok_pkg::C_GT);
            put_text();
            put_close_tag();
        end
    endtask

    task automatic gen_document();
        logic [7:0] b;
        int k;
        doc_bytes.delete();
        repeat ($urandom_range(4, 1)) begin
            put_text();
            case ($urandom_range(9))
                0: begin
                    put(xmltok_pkg::C_LT);
                    put(xmltok_pkg::C_BANG);
                    repeat ($urandom_range(4))
                        put($urandom_range(2) ? 8'h63 : xmltok_pkg::C_DASH);
                    put(xmltok_pkg::C_DASH);
                    put(xmltok_pkg::C_DASH);
                    if ($urandom_range(1))
                        put(xmltok_pkg::C_DASH);
                    put(xmltok_pkg::C_GT);
                end
                1: begin
                    put(xmltok_pkg::C_LT);
                    put(xmltok_pkg::C_QMARK);
                    repeat ($urandom_range(5)) begin
                        b = 8'($urandom_range(255));
                        put((b == xmltok_pkg::C_GT) ? 8'h78 : b);
                    end
                    put(xmltok_pkg::C_GT);
                end
                2: put_close_tag();
                default: put_element();
            endcase
        end
        // cut some documents short so they end mid-construct
        if ($urandom_range(7) == 0) begin
            k = $urandom_range(doc_bytes.size() - 1);
            doc_bytes = doc_bytes[0:k];
        end
        doc_bytes[0].nd = ($urandom_range(9) != 0);
    endtask

    initial begin
        int n;
        int random_start;
        int directed_items;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item  = '0;
        i_ready = 1'b0;
        calm    = 1'b0;
        restart_parser();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // plain text, extremes of the byte range
        row(8'h00, 1'b1, 1, xmltok_pkg::EV_TEXT, xmltok_pkg::ER_NONE);
        row(8'hFF, 1'b0, 1, xmltok_pkg::EV_TEXT, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_NL, 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        // declaration is swallowed
        row(xmltok_pkg::C_LT, 1'b0, 1, xmltok_pkg::EV_TEXTEND, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_QMARK, 1'b0, 1, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row("x", 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_GT, 1'b0, 1, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        // comment with a stray dash and a triple-dash ending
        row(xmltok_pkg::C_LT, 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_BANG, 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_DASH, 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row("q", 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_DASH, 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_DASH, 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_DASH, 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_GT, 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        // start tag, two attributes with both quotes, self closing
        row(xmltok_pkg::C_LT, 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row("a", 1'b0, 1, xmltok_pkg::EV_TAG, xmltok_pkg::ER_NONE);
        row("9", 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(" ", 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row("_", 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_EQ, 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_DQUOT, 1'b0, 1, xmltok_pkg::EV_VSTART, xmltok_pkg::ER_NONE);
        row(8'h80, 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_SQUOT, 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(8'h01, 1'b0, 1, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_DQUOT, 1'b0, 1, xmltok_pkg::EV_COMMIT, xmltok_pkg::ER_NONE);
        row("b", 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_EQ, 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_SQUOT, 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_SQUOT, 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_SLASH, 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_GT, 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        // close tag with padding
        row(xmltok_pkg::C_LT, 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_SLASH, 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(" ", 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row("a", 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row("1", 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(" ", 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_GT, 1'b0, 1, xmltok_pkg::EV_EEND, xmltok_pkg::ER_NONE);
        // each error, then a byte dropped while halted
        row(xmltok_pkg::C_LT, 1'b1, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row("#", 1'b0, 1, xmltok_pkg::EV_ERROR, xmltok_pkg::ER_TAG_CHAR);
        row("a", 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_LT, 1'b1, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row("a", 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(" ", 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row("#", 1'b0, 1, xmltok_pkg::EV_ERROR, xmltok_pkg::ER_ATTR_FIRST);
        row(xmltok_pkg::C_LT, 1'b1, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row("a", 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_SLASH, 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row("x", 1'b0, 1, xmltok_pkg::EV_ERROR, xmltok_pkg::ER_SLASH);
        row(xmltok_pkg::C_LT, 1'b1, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row("a", 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(" ", 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row("b", 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row("#", 1'b0, 1, xmltok_pkg::EV_ERROR, xmltok_pkg::ER_ATTR_CHAR);
        row(xmltok_pkg::C_LT, 1'b1, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row("a", 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(" ", 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row("b", 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_EQ, 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row("x", 1'b0, 1, xmltok_pkg::EV_ERROR, xmltok_pkg::ER_NO_VALUE);
        row(xmltok_pkg::C_LT, 1'b1, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_SLASH, 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row("1", 1'b0, 1, xmltok_pkg::EV_ERROR, xmltok_pkg::ER_CLOSE_LEAD);
        row(xmltok_pkg::C_LT, 1'b1, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row(xmltok_pkg::C_SLASH, 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row("a", 1'b0, 0, xmltok_pkg::EV_NONE, xmltok_pkg::ER_NONE);
        row("#", 1'b0, 1, xmltok_pkg::EV_ERROR, xmltok_pkg::ER_CLOSE_CHAR);

        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i].b, dir_rows[i].nd, n);
            // hand-typed rows pin event and code instead of the mirrored tokenizer
            if (dir_rows[i].typed && n == 1) begin
                pending_tokens[pending_tokens.size() - 1].event_res  = dir_rows[i].ev;
                pending_tokens[pending_tokens.size() - 1].error_code = dir_rows[i].err;
            end
        end
        directed_items = bytes_sent;

        // random documents; the first stretch runs with no idling on either side
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_ITEMS) begin
            calm = (bytes_sent - random_start < CALM_ITEMS);
            gen_document();
            docs_sent++;
            foreach (doc_bytes[i])
                send_byte(doc_bytes[i].b, doc_bytes[i].nd, n);
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        while (pending_tokens.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes: %0d directed, the rest in %0d random docs",
                 bytes_sent, directed_items, docs_sent);
        $display("Scored %0d tokens; %0d bytes were dropped while halted",
                 tokens_checked, bytes_sent - bytes_tokenized);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
hdl/xmltok_pkg.sv
hdl/xml_markup_tokenizer_unit.sv
tb/testbench.sv
